// ===== hdl/gas_sensor_reply_frame_checker_core_assert.svh =====
// Assertion macros shared by the frame checker RTL.
`ifndef GAS_SENSOR_REPLY_FRAME_CHECKER_CORE_ASSERT_SVH
`define GAS_SENSOR_REPLY_FRAME_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GSRFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gsrfc assertion failed");

// Next-cycle implication, checked out of reset.
`define GSRFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gsrfc assertion failed");

`endif

// ===== hdl/gsrfc_pkg.sv =====
// Types, constants and helpers of the gas sensor reply frame checker.
`default_nettype none
package gsrfc_pkg;

  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] FRAME_LEN  = 4'd9;
  localparam logic [CNT_W-1:0] IDX_START  = 4'd0;
  localparam logic [CNT_W-1:0] IDX_CMD    = 4'd1;
  localparam logic [CNT_W-1:0] IDX_HIGH   = 4'd2;
  localparam logic [CNT_W-1:0] IDX_LOW    = 4'd3;
  localparam logic [CNT_W-1:0] IDX_CHECK  = 4'd8;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND = 2'd1;

  localparam logic [7:0] START_BYTE_RST   = 8'hFF;
  localparam logic [7:0] COMMAND_BYTE_RST = 8'h86;

  localparam logic [15:0] FAIL_BASE = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NO_ANSWER      = 3'd1,
    ST_WRONG_LENGTH   = 3'd2,
    ST_WRONG_ID       = 3'd3,
    ST_WRONG_CHECKSUM = 3'd4,
    ST_SENSOR_FAILED  = 3'd5
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [12:0] reading;
    logic [15:0] reported_value;
  } res_t;

  // Build a result; failures report the fixed base minus the status.
  function automatic res_t make_result(status_e st, logic [12:0] rd);
    res_t r;
    r.status  = st;
    r.reading = rd;
    if (st == ST_OK) begin
      r.reported_value = {3'b000, rd};
    end else begin
      r.reported_value = FAIL_BASE - {13'd0, st};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/gsrfc_in_reg.sv =====
// Input register of the frame checker.
`default_nettype none
module gsrfc_in_reg
  import gsrfc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       take_i,
  output logic            vld_o,
  output logic            op_o,
  output logic [7:0]      byte_o
);

  logic       vld_q, vld_d;
  logic       op_q;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !vld_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= op_i;
      byte_q <= byte_value_i;
    end
  end

  assign vld_o  = vld_q;
  assign op_o   = op_q;
  assign byte_o = byte_q;

endmodule
`default_nettype wire

// ===== hdl/gsrfc_frame.sv =====
// Frame state and the single-pass check of one item.
`default_nettype none
`include "gas_sensor_reply_frame_checker_core_assert.svh"
module gsrfc_frame
  import gsrfc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic       op_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] start_byte_i,
  input  wire logic [7:0] command_byte_i,
  output logic            res_vld_o,
  output res_t            res_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic             hdr_q, hdr_d;
  logic [7:0]       high_q, high_d;
  logic [7:0]       low_q, low_d;
  logic [7:0]       sum_neg;

  assign sum_neg = 8'd0 - sum_q;

  always_comb begin
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    hdr_d     = hdr_q;
    high_d    = high_q;
    low_d     = low_q;
    res_vld_o = 1'b0;
    res_o     = make_result(ST_OK, 13'd0);
    if (fire_i) begin
      if (op_i == OP_END) begin
        cnt_d = '0;
        sum_d = '0;
        hdr_d = 1'b1;
        if (cnt_q == IDX_START) begin
          res_vld_o = 1'b1;
          res_o     = make_result(ST_NO_ANSWER, 13'd0);
        end else if (cnt_q < FRAME_LEN) begin
          res_vld_o = 1'b1;
          res_o     = make_result(ST_WRONG_LENGTH, 13'd0);
        end
      end else if (cnt_q < FRAME_LEN) begin
        cnt_d = cnt_q + 4'd1;
        case (cnt_q)
          IDX_START: begin
            hdr_d = (byte_i == start_byte_i);
          end
          IDX_CMD: begin
            hdr_d = hdr_q && (byte_i == command_byte_i);
            sum_d = byte_i;
          end
          IDX_HIGH: begin
            high_d = byte_i;
            sum_d  = sum_q + byte_i;
          end
          IDX_LOW: begin
            low_d = byte_i;
            sum_d = sum_q + byte_i;
          end
          IDX_CHECK: begin
            res_vld_o = 1'b1;
            if (!hdr_q) begin
              res_o = make_result(ST_WRONG_ID, 13'd0);
            end else if (sum_neg != byte_i) begin
              res_o = make_result(ST_WRONG_CHECKSUM, 13'd0);
            end else if (high_q[7]) begin
              res_o = make_result(ST_SENSOR_FAILED, 13'd0);
            end else begin
              res_o = make_result(ST_OK, {high_q[4:0], low_q});
            end
          end
          default: begin
            sum_d = sum_q + byte_i;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      hdr_q <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      hdr_q <= hdr_d;
    end
  end

  // Frame bytes at indexes two and three: written before any read, no reset.
  always_ff @(posedge clk_i) begin
    high_q <= high_d;
    low_q  <= low_d;
  end

  `GSRFC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= FRAME_LEN)
  `GSRFC_ASSERT_IMP(a_res_on_ninth, res_vld_o && (op_i == OP_BYTE), fire_i && (cnt_q == IDX_CHECK))
  `GSRFC_ASSERT_NXT(a_end_clears, fire_i && (op_i == OP_END), (cnt_q == '0) && (sum_q == '0) && hdr_q)

endmodule
`default_nettype wire

// ===== hdl/gsrfc_out_skid.sv =====
// Result register with one skid entry.
`default_nettype none
`include "gas_sensor_reply_frame_checker_core_assert.svh"
module gsrfc_out_skid
  import gsrfc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t push_data_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  logic out_vld_q, out_vld_d;
  logic skid_vld_q, skid_vld_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic drain;

  assign drain  = out_vld_q && out_ready_i;
  assign room_o = !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (drain) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!out_vld_d) begin
        out_vld_d = 1'b1;
        out_d     = push_data_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `GSRFC_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q)
  `GSRFC_ASSERT_IMP(a_push_has_room, push_i, !skid_vld_q)

endmodule
`default_nettype wire

// ===== hdl/gas_sensor_reply_frame_checker_core.sv =====
// Top level of the nine-byte gas sensor reply frame checker.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   op_i, byte_value_i
//   out      output     out_valid_o / out_ready_i status_o, reading_o, reported_value_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while the skid entry is free: an item is checked straight
// out of the input register once the output side has room; a result it makes
// is registered in the result register before it is valid at the output.
// Reset clears the frame count, checksum and handshake flags, sets the header
// match and loads the default start and command bytes. A stalled output fills
// the skid entry first; the input side stops only when that entry is also taken.
`default_nettype none
module gas_sensor_reply_frame_checker_core
  import gsrfc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 op_i,
  input  wire logic [7:0]           byte_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic [12:0]               reading_o,
  output logic [15:0]               reported_value_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i
);

  logic [7:0] start_byte_q, start_byte_d;
  logic [7:0] command_byte_q, command_byte_d;
  logic       stg_vld;
  logic       stg_op;
  logic [7:0] stg_byte;
  logic       room;
  logic       fire;
  logic       res_vld;
  res_t       res;
  res_t       out_data;

  // Configuration: always ready; indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    start_byte_d   = start_byte_q;
    command_byte_d = command_byte_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START:   start_byte_d   = cfg_data_i;
        CFG_COMMAND: command_byte_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q   <= START_BYTE_RST;
      command_byte_q <= COMMAND_BYTE_RST;
    end else begin
      start_byte_q   <= start_byte_d;
      command_byte_q <= command_byte_d;
    end
  end

  // Advance the staged item only when the output side can hold a result.
  assign fire = stg_vld && room;

  gsrfc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .byte_value_i (byte_value_i),
    .take_i       (fire),
    .vld_o        (stg_vld),
    .op_o         (stg_op),
    .byte_o       (stg_byte)
  );

  // Frame state: count, running checksum, header match, reading bytes.
  gsrfc_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .op_i           (stg_op),
    .byte_i         (stg_byte),
    .start_byte_i   (start_byte_q),
    .command_byte_i (command_byte_q),
    .res_vld_o      (res_vld),
    .res_o          (res)
  );

  // Hold results while the consumer stalls.
  gsrfc_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign status_o         = out_data.status;
  assign reading_o        = out_data.reading;
  assign reported_value_o = out_data.reported_value;

endmodule
`default_nettype wire
